// File: rtl/core/vgss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time table functions for the
// variable-resolution Gaussian smoother. No dependencies.
package vgss_pkg;

  localparam int unsigned MAX_POINTS_DEF      = 4096;
  localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;

  // Field widths fixed by the interface
  localparam int unsigned WL_W     = 32;
  localparam int unsigned FLUX_W   = 32;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RES   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RES_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RES_SLOPE  = 1'd1;

  // 0.42466090 in Q0.32
  localparam logic [30:0] SIGMA_K = 31'd1823904678;

  // Divider operand width
  localparam int unsigned DIV_W = 64;

  // Table entry width: 1.0 in Q.16 needs 17 bits
  localparam int unsigned ENTRY_W = 17;

  // Normalized u = d / sigma stays below 5.0 in Q.16
  localparam int unsigned U_W   = 19;
  localparam int unsigned USQ_W = 2 * U_W;

  // Divide by 25 through a reciprocal with one correction step
  localparam int unsigned      DIV25       = 25;
  localparam int unsigned      RECIP_SHIFT = 24;
  localparam logic [19:0]      RECIP_25    = 20'd671088;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  // exp(-a) in Q.32 by a 15-term Taylor series, a in Q.32
  function automatic logic [63:0] exp_step(logic [63:0] a);
    logic [63:0] t;
    logic [63:0] q;
    t = 64'h1_0000_0000;
    q = t;
    t = ((t * a) >> 32) / 64'd1;  q = q - t;
    t = ((t * a) >> 32) / 64'd2;  q = q + t;
    t = ((t * a) >> 32) / 64'd3;  q = q - t;
    t = ((t * a) >> 32) / 64'd4;  q = q + t;
    t = ((t * a) >> 32) / 64'd5;  q = q - t;
    t = ((t * a) >> 32) / 64'd6;  q = q + t;
    t = ((t * a) >> 32) / 64'd7;  q = q - t;
    t = ((t * a) >> 32) / 64'd8;  q = q + t;
    t = ((t * a) >> 32) / 64'd9;  q = q - t;
    t = ((t * a) >> 32) / 64'd10; q = q + t;
    t = ((t * a) >> 32) / 64'd11; q = q - t;
    t = ((t * a) >> 32) / 64'd12; q = q + t;
    t = ((t * a) >> 32) / 64'd13; q = q - t;
    t = ((t * a) >> 32) / 64'd14; q = q + t;
    return q;
  endfunction

  // Entry k: q^k in Q.32, rounded to Q.16
  function automatic logic [ENTRY_W-1:0] exp_entry(int unsigned k, logic [63:0] q);
    logic [63:0] p;
    p = 64'h1_0000_0000;
    for (int unsigned i = 0; i < k; i++) begin
      p = (p * q) >> 32;
    end
    return ENTRY_W'((p + 64'h8000) >> 16);
  endfunction

endpackage

// File: rtl/core/variable_gaussian_spectral_smoother_unit.sv
`timescale 1ns / 1ps
// Top level of the variable-resolution Gaussian smoother: sequencer, datapath
// and sample stores. Depends on vgss_pkg, vgss_ram, vgss_div, vgss_exp_rom.
//
// A load request writes one grid sample (wavelength and flux) into two
// single-write, single-read RAMs; samples beyond MAX_POINTS are dropped.
// A compute request runs alone: setup (the resolving power, sigma through
// the shared divider, and up to 23 normalizing shifts), then a walk over
// all n stored samples, where the divider again sets the pace for each
// sample inside the kernel window, and a closing division.
// The stores have no reset; no clearing pass runs. A finished result waits in
// the output register while the next request is taken.
module variable_gaussian_spectral_smoother_unit #(
  parameter int unsigned MAX_POINTS      = vgss_pkg::MAX_POINTS_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = vgss_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vgss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vgss_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic                           start_req_i,
  input  logic [vgss_pkg::WL_W-1:0]      wavelength_i,
  input  logic signed [vgss_pkg::FLUX_W-1:0] flux_in_i,
  input  logic [vgss_pkg::IDX_W-1:0]     point_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [vgss_pkg::FLUX_W-1:0] flux_out_o,
  output logic [vgss_pkg::IDX_W-1:0]     out_index_o,
  output logic [vgss_pkg::STATUS_W-1:0]  status_o
);
  import vgss_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned XW    = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned KW    = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned DW    = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int unsigned LIM25 = DIV25 * EXP_TABLE_DEPTH;
  localparam int unsigned TW    = $clog2(LIM25);
  localparam int unsigned SPW   = USQ_W + DW;
  localparam int unsigned TFW   = SPW - 32;
  localparam int unsigned KPW   = TW + 20;
  localparam int unsigned WSW   = 32 + CW;

  typedef enum logic [22:0] {
    S_IDLE = 23'h000001,
    S_LOOK = 23'h000002,
    S_MUL  = 23'h000004,
    S_RES  = 23'h000008,
    S_SDIV = 23'h000010,
    S_NORM = 23'h000020,
    S_PRE  = 23'h000040,
    S_PREW = 23'h000080,
    S_PRD  = 23'h000100,
    S_PLD  = 23'h000200,
    S_EVAL = 23'h000400,
    S_UDIV = 23'h000800,
    S_SQ   = 23'h001000,
    S_SCL  = 23'h002000,
    S_K1   = 23'h004000,
    S_K2   = 23'h008000,
    S_WT   = 23'h010000,
    S_PROD = 23'h020000,
    S_ACC  = 23'h040000,
    S_NXT  = 23'h080000,
    S_FIN  = 23'h100000,
    S_QDIV = 23'h200000,
    S_EMIT = 23'h400000
  } state_e;

  state_e state_q, state_d;

  // Control registers
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CFG_W-1:0] res_offset_q;
  logic [CFG_W-1:0] res_slope_q;
  logic             out_valid_q;

  // Payload registers
  logic [IDX_W-1:0]      idx_q;
  logic [FLUX_W-1:0]     res_flux_q;
  logic [STATUS_W-1:0]   res_status_q;
  logic [WL_W-1:0]       lam_i_q;
  logic [FLUX_W-1:0]     flux_i_q;
  logic signed [64:0]    slope_prod_q;
  logic [62:0]           lamk_q;
  logic [DIV_W-1:0]      s_norm_q;
  logic [62:0]           lim_q;
  logic                  all_q;
  logic [4:0]            sh_q;
  logic [CW-1:0]         j_q;
  logic [WL_W-1:0]       prev_q, cur_q, next_q;
  logic [FLUX_W-1:0]     flux_j_q;
  logic [WL_W-1:0]       width_q;
  logic [U_W-1:0]        u_q;
  logic [USQ_W-1:0]      usq_q;
  logic                  big_q;
  logic [TW-1:0]         tc_q;
  logic [KW-1:0]         q0_q;
  logic [KW-1:0]         k_q;
  logic [31:0]           w_q;
  logic [63:0]           prod_q;
  logic [63:0]           acc_q;
  logic [WSW-1:0]        wsum_q;
  logic                  neg_q;
  logic [FLUX_W-1:0]     flux_out_q;
  logic [IDX_W-1:0]      out_index_q;
  logic [STATUS_W-1:0]   status_q;

  // Memory and unit connections
  logic            mem_we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   wl_raddr, fl_raddr;
  logic [WL_W-1:0] wl_rdata;
  logic [FLUX_W-1:0] fl_rdata;
  div_req_t        div_req;
  div_rsp_t        div_rsp;
  logic [ENTRY_W-1:0] entry;

  // Combinational datapath
  logic [CW-1:0]        load_base;
  logic                 short_grid;
  logic [XW-1:0]        idx_ext;
  logic [AW-1:0]        idx_addr;
  logic [CW-1:0]        jp1;
  logic signed [35:0]   r_d;
  logic                 r_bad;
  logic [62:0]          lamk_d;
  logic signed [64:0]   slope_prod_d;
  logic [WL_W-1:0]      d_abs;
  logic [51:0]          num;
  logic [51:0]          num_sh;
  logic                 in_win;
  logic [WL_W-1:0]      width_d;
  logic [SPW-1:0]       scl_prod;
  logic [TFW-1:0]       t_val;
  logic [KPW-1:0]       k_prod;
  logic [TW-1:0]        rem25;
  logic [48:0]          w_prod;
  logic signed [64:0]   fw_prod;
  logic [64:0]          acc_sum;
  logic [63:0]          acc_sat;
  logic [63:0]          acc_mag;
  logic [31:0]          quot_neg;
  logic [FLUX_W-1:0]    quot_sat;
  logic                 out_load;
  logic                 out_take;

  vgss_ram #(.WIDTH(WL_W), .DEPTH(MAX_POINTS)) u_wl_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wavelength_i),
    .raddr_i (wl_raddr),
    .rdata_o (wl_rdata)
  );

  vgss_ram #(.WIDTH(FLUX_W), .DEPTH(MAX_POINTS)) u_flux_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (flux_in_i),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  vgss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  vgss_exp_rom #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_rom (
    .k_i     (k_q),
    .entry_o (entry)
  );

  assign load_base  = start_req_i ? '0 : cnt_q;
  assign waddr      = load_base[AW-1:0];
  assign short_grid = (cnt_q < CW'(2)) || (XW'(point_index_i) >= XW'(cnt_q));
  assign idx_ext    = XW'(idx_q);
  assign idx_addr   = idx_ext[AW-1:0];
  assign jp1        = j_q + CW'(1);

  // Resolving power in Q.12 and the sigma numerator
  assign slope_prod_d = $signed(res_slope_q) * $signed({1'b0, wl_rdata});
  assign lamk_d       = 63'(wl_rdata) * 63'(SIGMA_K);
  assign r_d          = 36'($signed(res_offset_q)) + 36'(slope_prod_q >>> 30);
  assign r_bad        = r_d[35] || (r_d == '0);

  // Window test and bin width for the current sample
  assign d_abs  = (cur_q >= lam_i_q) ? (cur_q - lam_i_q) : (lam_i_q - cur_q);
  assign num    = {d_abs, 20'd0};
  assign num_sh = num >> sh_q;
  assign in_win = all_q || (63'(num) <= lim_q);

  always_comb begin
    if (j_q == '0) begin
      width_d = (next_q >= cur_q) ? (next_q - cur_q) : '0;
    end else if (jp1 == cnt_q) begin
      width_d = (cur_q >= prev_q) ? (cur_q - prev_q) : '0;
    end else begin
      width_d = (next_q >= prev_q) ? ((next_q - prev_q) >> 1) : '0;
    end
  end

  // Table index: u^2 * depth / (25 * 2^32)
  assign scl_prod = SPW'(usq_q) * SPW'(EXP_TABLE_DEPTH);
  assign t_val    = scl_prod[SPW-1:32];
  assign k_prod   = KPW'(tc_q) * KPW'(RECIP_25);
  assign rem25    = tc_q - TW'(q0_q) * TW'(DIV25);

  assign w_prod  = 49'(entry) * 49'(width_q);
  assign fw_prod = $signed({1'b0, w_q}) * $signed(flux_j_q);

  // Saturating accumulate
  assign acc_sum = {acc_q[63], acc_q} + {prod_q[63], prod_q};
  always_comb begin
    if (acc_sum[64] != acc_sum[63]) begin
      acc_sat = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_sat = acc_sum[63:0];
    end
  end
  assign acc_mag = acc_q[63] ? (64'd0 - acc_q) : acc_q;

  // Quotient sign restore and saturation
  assign quot_neg = 32'd0 - div_rsp.quot[31:0];
  always_comb begin
    if (!neg_q) begin
      quot_sat = (div_rsp.quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_rsp.quot[31:0];
    end else begin
      quot_sat = (div_rsp.quot > 64'h8000_0000) ? 32'h8000_0000 : quot_neg;
    end
  end

  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    mem_we           = 1'b0;
    wl_raddr         = '0;
    fl_raddr         = '0;
    div_req          = '0;
    out_load         = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_LOAD) begin
            if (load_base < CW'(MAX_POINTS)) begin
              mem_we = 1'b1;
              cnt_d  = load_base + CW'(1);
            end else begin
              cnt_d = load_base;
            end
          end else if (short_grid) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        wl_raddr = idx_addr;
        fl_raddr = idx_addr;
        state_d  = S_MUL;
      end
      S_MUL: state_d = S_RES;
      S_RES: begin
        if (r_bad) begin
          state_d = S_EMIT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(lamk_q);
          div_req.divisor  = DIV_W'(r_d[34:0]);
          state_d          = S_SDIV;
        end
      end
      S_SDIV: begin
        if (div_rsp.done) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (s_norm_q[DIV_W-1:40] == '0) begin
          state_d = S_PRE;
        end
      end
      S_PRE: begin
        wl_raddr = '0;
        state_d  = S_PREW;
      end
      S_PREW: state_d = S_PRD;
      S_PRD: begin
        wl_raddr = jp1[AW-1:0];
        fl_raddr = j_q[AW-1:0];
        state_d  = S_PLD;
      end
      S_PLD: state_d = S_EVAL;
      S_EVAL: begin
        if (!in_win) begin
          state_d = S_NXT;
        end else if (s_norm_q == '0) begin
          state_d = S_SQ;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'({num_sh, 16'd0});
          div_req.divisor  = s_norm_q;
          state_d          = S_UDIV;
        end
      end
      S_UDIV: begin
        if (div_rsp.done) begin
          state_d = S_SQ;
        end
      end
      S_SQ:   state_d = S_SCL;
      S_SCL:  state_d = S_K1;
      S_K1:   state_d = S_K2;
      S_K2:   state_d = S_WT;
      S_WT:   state_d = S_PROD;
      S_PROD: state_d = S_ACC;
      S_ACC:  state_d = S_NXT;
      S_NXT: begin
        if (jp1 == cnt_q) begin
          state_d = S_FIN;
        end else begin
          state_d = S_PRD;
        end
      end
      S_FIN: begin
        if (wsum_q == '0) begin
          state_d = S_EMIT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = acc_mag;
          div_req.divisor  = DIV_W'(wsum_q);
          state_d          = S_QDIV;
        end
      end
      S_QDIV: begin
        if (div_rsp.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      res_offset_q <= '0;
      res_slope_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_RES_OFFSET: res_offset_q <= cfg_data_i;
          REG_RES_SLOPE:  res_slope_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (cmd_i == CMD_COMPUTE)) begin
          idx_q        <= point_index_i;
          res_flux_q   <= '0;
          res_status_q <= short_grid ? STATUS_BAD_INDEX : STATUS_OK;
        end
      end
      S_MUL: begin
        lam_i_q      <= wl_rdata;
        flux_i_q     <= fl_rdata;
        slope_prod_q <= slope_prod_d;
        lamk_q       <= lamk_d;
      end
      S_RES: begin
        res_status_q <= r_bad ? STATUS_BAD_RES : STATUS_OK;
      end
      S_SDIV: begin
        if (div_rsp.done) begin
          s_norm_q <= div_rsp.quot;
          all_q    <= div_rsp.quot[DIV_W-1:60] != '0;
          lim_q    <= 63'(div_rsp.quot) + (63'(div_rsp.quot) << 2);
          sh_q     <= '0;
        end
      end
      S_NORM: begin
        if (s_norm_q[DIV_W-1:40] != '0) begin
          s_norm_q <= s_norm_q >> 1;
          sh_q     <= sh_q + 5'd1;
        end
      end
      S_PRE: begin
        j_q    <= '0;
        acc_q  <= '0;
        wsum_q <= '0;
      end
      S_PREW: cur_q <= wl_rdata;
      S_PLD: begin
        next_q   <= wl_rdata;
        flux_j_q <= fl_rdata;
      end
      S_EVAL: begin
        width_q <= width_d;
        u_q     <= '0;
      end
      S_UDIV: begin
        if (div_rsp.done) begin
          u_q <= div_rsp.quot[U_W-1:0];
        end
      end
      S_SQ: usq_q <= USQ_W'(u_q) * USQ_W'(u_q);
      S_SCL: begin
        big_q <= t_val >= TFW'(LIM25);
        tc_q  <= t_val[TW-1:0];
      end
      S_K1: q0_q <= k_prod[KW+RECIP_SHIFT-1:RECIP_SHIFT];
      S_K2: begin
        if (big_q) begin
          k_q <= KW'(EXP_TABLE_DEPTH - 1);
        end else if (rem25 >= TW'(DIV25)) begin
          k_q <= q0_q + KW'(1);
        end else begin
          k_q <= q0_q;
        end
      end
      S_WT: w_q <= w_prod[47:16];
      S_PROD: begin
        prod_q <= fw_prod[63:0];
        wsum_q <= wsum_q + WSW'(w_q);
      end
      S_ACC: acc_q <= acc_sat;
      S_NXT: begin
        prev_q <= cur_q;
        cur_q  <= next_q;
        j_q    <= jp1;
      end
      S_FIN: begin
        neg_q <= acc_q[63];
        if (wsum_q == '0) begin
          res_flux_q <= flux_i_q;
        end
      end
      S_QDIV: begin
        if (div_rsp.done) begin
          res_flux_q <= quot_sat;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      flux_out_q  <= res_flux_q;
      out_index_q <= idx_q;
      status_q    <= res_status_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign flux_out_o  = flux_out_q;
  assign out_index_o = out_index_q;
  assign status_o    = status_q;

endmodule

// File: rtl/core/vgss_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module vgss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/vgss_div.sv
`timescale 1ns / 1ps
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on vgss_pkg for the request and response types.
module vgss_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vgss_pkg::div_req_t req_i,
  output vgss_pkg::div_rsp_t rsp_o
);
  import vgss_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DIV_W-1:0] dvs_q;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             fits;

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// File: rtl/core/vgss_exp_rom.sv
`timescale 1ns / 1ps
// Constant table of exp(-12.5 k / depth) in Q.16, built at elaboration.
// Depends on vgss_pkg for the table functions.
module vgss_exp_rom #(
  parameter int unsigned EXP_TABLE_DEPTH = vgss_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] k_i,
  output logic [vgss_pkg::ENTRY_W-1:0]       entry_o
);
  import vgss_pkg::*;

  // 12.5 / depth in Q.32 and its exponential per step
  localparam logic [63:0] STEP_A = (64'd25 << 31) / EXP_TABLE_DEPTH;
  localparam logic [63:0] STEP_Q = exp_step(STEP_A);

  logic [ENTRY_W-1:0] tab [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
    assign tab[g] = exp_entry(g, STEP_Q);
  end

  assign entry_o = tab[k_i];

endmodule
